FILE: hw/rtl/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// implication checked in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

FILE: hw/rtl/bdfm_pkg.sv
// types and constants for the boxcar decimator and fm discriminator
`timescale 1ns / 1ps
package bdfm_pkg;

    typedef struct packed {
        logic signed [15:0] sample_a;
        logic signed [15:0] sample_b;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] out_a;
        logic signed [15:0] out_b;
        logic               out_b_valid;
    } out_item_t;

    // register indexes
    localparam logic [1:0] REG_MODE     = 2'd0;
    localparam logic [1:0] REG_NUM_CH   = 2'd1;
    localparam logic [1:0] REG_DECIM    = 2'd2;
    localparam logic [1:0] REG_FM_GAIN  = 2'd3;

    // largest factor; sum and divider widths are sized for it
    localparam int MAX_DECIMATION = 256;

    localparam int CORDIC_STEPS = 24;

    // request from front to back: frame sums plus divisor and kind
    typedef struct packed {
        logic signed [24:0] sum_a;
        logic signed [24:0] sum_b;
        logic [12:0]        factor;
        logic               fm;
        logic               two_ch;
    } job_t;

    // arctangent table in 2^32 per turn
    function automatic logic [31:0] atan_turn(input logic [4:0] k);
        logic [31:0] r;
        begin
            unique case (k)
                5'd0:  r = 32'd536870912;
                5'd1:  r = 32'd316933406;
                5'd2:  r = 32'd167458907;
                5'd3:  r = 32'd85004756;
                5'd4:  r = 32'd42667331;
                5'd5:  r = 32'd21354465;
                5'd6:  r = 32'd10679838;
                5'd7:  r = 32'd5340245;
                5'd8:  r = 32'd2670163;
                5'd9:  r = 32'd1335087;
                5'd10: r = 32'd667544;
                5'd11: r = 32'd333772;
                5'd12: r = 32'd166886;
                5'd13: r = 32'd83443;
                5'd14: r = 32'd41721;
                5'd15: r = 32'd20860;
                5'd16: r = 32'd10430;
                5'd17: r = 32'd5215;
                5'd18: r = 32'd2607;
                5'd19: r = 32'd1303;
                5'd20: r = 32'd651;
                5'd21: r = 32'd325;
                5'd22: r = 32'd162;
                5'd23: r = 32'd81;
                default: r = 32'd0;
            endcase
            return r;
        end
    endfunction

endpackage

FILE: hw/rtl/bdfm_front.sv
// front end: accumulates frames and issues a request per decimated frame
`timescale 1ns / 1ps
module bdfm_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  bdfm_pkg::in_item_t in_data,
    input  logic [8:0]         decim_factor,
    input  logic               mode,
    input  logic [1:0]         num_channels,
    input  logic               factor_write,
    input  logic [8:0]         factor_wdata,
    output logic               job_valid,
    input  logic               job_full,
    output bdfm_pkg::job_t     job
);
    localparam int FW = 13;

    logic signed [24:0] sum_a_reg, sum_b_reg;
    logic [FW-1:0]      left_reg;
    logic [FW-1:0]      eff;
    logic [FW-1:0]      eff_w;
    logic               take;
    logic signed [24:0] na, nb;

    // clamp the factor to 1..MAX_DECIMATION
    function automatic logic [FW-1:0] clampf(input logic [8:0] v);
        logic [FW-1:0] r;
        begin
            r = FW'(v);
            if (r == '0)
                r = FW'(1);
            else if (r > FW'(bdfm_pkg::MAX_DECIMATION))
                r = FW'(bdfm_pkg::MAX_DECIMATION);
            return r;
        end
    endfunction

    assign eff      = clampf(decim_factor);
    assign eff_w    = clampf(factor_wdata);
    assign in_stall = job_full;
    assign take     = in_valid && !in_stall;
    assign na = sum_a_reg + 25'(in_data.sample_a);
    assign nb = sum_b_reg + 25'(in_data.sample_b);

    assign job_valid  = take && (left_reg <= FW'(1));
    assign job.sum_a  = na;
    assign job.sum_b  = nb;
    assign job.factor = eff;
    assign job.fm     = mode;
    assign job.two_ch = (num_channels == 2'd2);

    // sums and frame counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_a_reg <= '0;
            sum_b_reg <= '0;
            left_reg  <= FW'(1);
        end
        else if (factor_write)
        begin
            sum_a_reg <= '0;
            sum_b_reg <= '0;
            left_reg  <= eff_w;
        end
        else if (take)
        begin
            if (left_reg > FW'(1))
            begin
                sum_a_reg <= na;
                sum_b_reg <= nb;
                left_reg  <= left_reg - FW'(1);
            end
            else
            begin
                sum_a_reg <= '0;
                sum_b_reg <= '0;
                left_reg  <= eff;
            end
        end
    end
endmodule

FILE: hw/rtl/bdfm_back.sv
// back end: divides sums, runs cordic and scales the phase step
`timescale 1ns / 1ps
module bdfm_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                job_valid,
    output logic                job_take,
    input  bdfm_pkg::job_t      job,
    input  logic [17:0]         fm_gain,
    output logic                out_valid,
    input  logic                out_stall,
    output bdfm_pkg::out_item_t out_data
);
    typedef enum logic [2:0] {S_IDLE, S_DIV, S_CORD, S_MUL, S_SCALE, S_OUT} state_t;

    state_t              state_reg;
    logic [4:0]          cnt_reg;
    logic [1:0]          ch_reg;
    logic [25:0]         mag_reg;
    logic                neg_reg;
    logic [25:0]         rem_reg;
    logic [12:0]         div_reg;
    logic signed [24:0]  sb_reg;
    logic signed [15:0]  mean_a_reg, mean_b_reg;
    logic                fm_reg, two_reg;
    logic signed [41:0]  x_reg, y_reg;
    logic [31:0]         ang_reg;
    logic [15:0]         last_phase_reg;
    logic signed [34:0]  prod_reg;
    logic                out_valid_reg;
    bdfm_pkg::out_item_t out_reg;

    // combinational helpers
    logic [25:0]         rtry;
    logic [26:0]         rsh;
    logic signed [41:0]  dx, dy;
    logic [15:0]         ph, du;
    logic signed [16:0]  d;
    logic [34:0]         pmag;
    logic [18:0]         r;
    logic signed [19:0]  rs;
    logic signed [15:0]  sat;

    // rounded operand: sum plus half factor, split into sign and magnitude
    function automatic logic [26:0] load(input logic signed [24:0] s, input logic [12:0] f);
        logic signed [25:0] v;
        begin
            v = 26'(s) + 26'(f >> 1);
            return {v[25], v[25] ? 26'(-v) : 26'(v)};
        end
    endfunction

    assign rsh  = {rem_reg, mag_reg[25]};
    assign rtry = 26'(rsh - 27'(div_reg));
    assign dx   = y_reg >>> cnt_reg;
    assign dy   = x_reg >>> cnt_reg;
    assign ph   = 16'((ang_reg + 32'h8000) >> 16);
    assign du   = ph - last_phase_reg;
    assign d    = du[15] ? 17'($signed({1'b1, du})) : 17'({1'b0, du});
    assign pmag = prod_reg[34] ? 35'(-prod_reg) : 35'(prod_reg);
    assign r    = 19'((pmag + 35'h8000) >> 16);
    assign rs   = prod_reg[34] ? -20'(r) : 20'(r);
    assign sat  = (rs > 20'sd32767) ? 16'sh7fff :
                  (rs < -20'sd32768) ? 16'sh8000 : 16'(rs);

    assign job_take  = (state_reg == S_IDLE) && job_valid;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // sequencer: two restoring divides, optional cordic and gain stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            last_phase_reg <= '0;
            cnt_reg        <= '0;
            ch_reg         <= '0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (job_valid)
                    begin
                        {neg_reg, mag_reg} <= load(job.sum_a, job.factor);
                        rem_reg <= '0;
                        div_reg <= job.factor;
                        sb_reg  <= job.sum_b;
                        fm_reg  <= job.fm;
                        two_reg <= job.two_ch;
                        cnt_reg <= '0;
                        ch_reg  <= '0;
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    // one quotient bit per cycle
                    if (rsh >= 27'(div_reg))
                    begin
                        rem_reg <= rtry;
                        mag_reg <= {mag_reg[24:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rsh[25:0];
                        mag_reg <= {mag_reg[24:0], 1'b0};
                    end
                    if (cnt_reg == 5'd25)
                    begin
                        cnt_reg <= '0;
                        if (ch_reg == 2'd0)
                        begin
                            mean_a_reg <= neg_reg
                                ? -16'({mag_reg[14:0], (rsh >= 27'(div_reg))})
                                : 16'({mag_reg[14:0], (rsh >= 27'(div_reg))});
                            {neg_reg, mag_reg} <= load(sb_reg, div_reg);
                            rem_reg <= '0;
                            ch_reg  <= 2'd1;
                        end
                        else
                        begin
                            mean_b_reg <= neg_reg
                                ? -16'({mag_reg[14:0], (rsh >= 27'(div_reg))})
                                : 16'({mag_reg[14:0], (rsh >= 27'(div_reg))});
                            state_reg <= fm_reg ? S_CORD : S_OUT;
                            ch_reg <= 2'd2;
                        end
                    end
                    else
                        cnt_reg <= cnt_reg + 5'd1;
                end
                S_CORD:
                begin
                    if (ch_reg == 2'd2)
                    begin
                        // prerotate by a half turn when i is negative
                        ch_reg <= 2'd3;
                        cnt_reg <= '0;
                        if (mean_b_reg < 0)
                        begin
                            x_reg   <= -(42'(mean_b_reg) <<< 20);
                            y_reg   <= -(42'(mean_a_reg) <<< 20);
                            ang_reg <= 32'h8000_0000;
                        end
                        else
                        begin
                            x_reg   <= 42'(mean_b_reg) <<< 20;
                            y_reg   <= 42'(mean_a_reg) <<< 20;
                            ang_reg <= '0;
                        end
                    end
                    else
                    begin
                        if (y_reg > 0)
                        begin
                            x_reg <= x_reg + dx;
                            y_reg <= y_reg - dy;
                            ang_reg <= ang_reg + bdfm_pkg::atan_turn(cnt_reg);
                        end
                        else
                        begin
                            x_reg <= x_reg - dx;
                            y_reg <= y_reg + dy;
                            ang_reg <= ang_reg - bdfm_pkg::atan_turn(cnt_reg);
                        end
                        if (cnt_reg == 5'(bdfm_pkg::CORDIC_STEPS - 1))
                            state_reg <= S_MUL;
                        else
                            cnt_reg <= cnt_reg + 5'd1;
                    end
                end
                S_MUL:
                begin
                    // origin has phase zero
                    if (mean_a_reg == 0 && mean_b_reg == 0)
                    begin
                        prod_reg <= $signed({17'd0, fm_gain}) * 35'($signed({1'b0,
                            16'(16'd0 - last_phase_reg)}) - (((16'd0 - last_phase_reg) >= 16'h8000)
                            ? 35'sd65536 : 35'sd0));
                        last_phase_reg <= '0;
                    end
                    else
                    begin
                        prod_reg <= $signed({17'd0, fm_gain}) * 35'(d);
                        last_phase_reg <= ph;
                    end
                    state_reg <= S_SCALE;
                end
                S_SCALE:
                begin
                    mean_a_reg <= sat;
                    mean_b_reg <= '0;
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg       <= 1'b1;
                        out_reg.out_a       <= mean_a_reg;
                        out_reg.out_b       <= (fm_reg || !two_reg) ? 16'sd0 : mean_b_reg;
                        out_reg.out_b_valid <= !fm_reg && two_reg;
                        state_reg           <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

FILE: hw/rtl/bdfm_queue.sv
// two entry request queue between front and back
`timescale 1ns / 1ps
module bdfm_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr,
    input  bdfm_pkg::job_t wdata,
    output logic           full,
    output logic           rd_valid,
    input  logic           rd,
    output bdfm_pkg::job_t rdata
);
    bdfm_pkg::job_t mem_reg [2];
    logic           wp_reg, rp_reg;
    logic [1:0]     cnt_reg;

    assign full     = cnt_reg == 2'd2;
    assign rd_valid = cnt_reg != 2'd0;
    assign rdata    = mem_reg[rp_reg];

    // pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr)
            begin
                mem_reg[wp_reg] <= wdata;
                wp_reg <= !wp_reg;
            end
            if (rd)
                rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + 2'(wr) - 2'(rd);
        end
    end
endmodule

FILE: hw/rtl/boxcar_decimator_fm_discriminator.sv
// top level of the boxcar decimator with fm discriminator
//  channel | direction | handshake
//  in      | input     | in_valid / in_stall
//  out     | output    | out_valid / out_stall
//  apb     | config    | psel penable pwrite pready
// a decimated frame passes the back end as two restoring divides, plus
// cordic and gain scaling in fm mode; the back end takes one job at a time
// frames that emit nothing just accumulate; the two entry queue absorbs bursts
// reset clears sums, frame counter and last phase; no clearing pass
// a stall on out holds the back end, which then fills the queue and stalls in
`timescale 1ns / 1ps
`include "assert_macros.svh"
module boxcar_decimator_fm_discriminator (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  bdfm_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output bdfm_pkg::out_item_t out_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    logic        mode_reg;
    logic [1:0]  num_ch_reg;
    logic [8:0]  decim_reg;
    logic [17:0] gain_reg;
    logic        wr_en;
    logic [1:0]  widx;
    logic        job_valid, job_full, q_valid, q_take;
    bdfm_pkg::job_t job_in, job_out;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign widx   = paddr[3:2];

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= 1'b0;
            num_ch_reg <= 2'd2;
            decim_reg  <= 9'd1;
            gain_reg   <= 18'd20971;
        end
        else if (wr_en)
        begin
            unique case (widx)
                bdfm_pkg::REG_MODE:    mode_reg   <= pwdata[0];
                bdfm_pkg::REG_NUM_CH:  num_ch_reg <= pwdata[1:0];
                bdfm_pkg::REG_DECIM:   decim_reg  <= pwdata[8:0];
                bdfm_pkg::REG_FM_GAIN: gain_reg   <= pwdata[17:0];
                default: ;
            endcase
        end
    end

    // register reads
    always_comb
    begin
        unique case (widx)
            bdfm_pkg::REG_MODE:    prdata = 32'(mode_reg);
            bdfm_pkg::REG_NUM_CH:  prdata = 32'(num_ch_reg);
            bdfm_pkg::REG_DECIM:   prdata = 32'(decim_reg);
            bdfm_pkg::REG_FM_GAIN: prdata = 32'(gain_reg);
            default:               prdata = '0;
        endcase
    end

    bdfm_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .in_data(in_data), .decim_factor(decim_reg), .mode(mode_reg),
        .num_channels(num_ch_reg),
        .factor_write(wr_en && widx == bdfm_pkg::REG_DECIM),
        .factor_wdata(pwdata[8:0]), .job_valid(job_valid), .job_full(job_full),
        .job(job_in)
    );

    bdfm_queue u_queue (
        .clk(clk), .rst_n(rst_n), .wr(job_valid), .wdata(job_in), .full(job_full),
        .rd_valid(q_valid), .rd(q_take), .rdata(job_out)
    );

    bdfm_back u_back (
        .clk(clk), .rst_n(rst_n), .job_valid(q_valid), .job_take(q_take),
        .job(job_out), .fm_gain(gain_reg), .out_valid(out_valid),
        .out_stall(out_stall), .out_data(out_data)
    );

    `ASSERT_IMPL(a_no_push_full, clk, rst_n, job_full, !job_valid, "push into full queue")
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid,
        "result dropped under stall")
    `ASSERT_IMPL(a_b_zero, clk, rst_n, out_valid && !out_data.out_b_valid,
        out_data.out_b == 16'sd0, "out_b nonzero while not valid")
endmodule
